[src/kmm_pkg.sv]
// Package: sizes, request/response types, state codes and report helpers for the report merger.
`timescale 1ns / 1ps
package kmm_pkg;

  localparam int MAX_DEVICES    = 8;
  localparam int REPORT_KEYS    = 6;
  localparam int USAGE_COUNT    = 256;
  localparam int MODIFIER_COUNT = 8;

  localparam int KEY_FIELDS = 6;
  localparam int LANES      = 4;
  localparam int LANE_W     = $clog2(LANES);
  localparam int ROWS       = (USAGE_COUNT + LANES - 1) / LANES;
  localparam int ROW_W      = (ROWS > 1) ? $clog2(ROWS) : 1;
  localparam int IDX_W      = ROW_W + LANE_W;
  localparam int MASK_W     = MAX_DEVICES;

  localparam logic [7:0] ERR_FIRST = 8'd1;
  localparam logic [7:0] ERR_LAST  = 8'd3;

  typedef logic [7:0]              usage_t;
  typedef logic [MASK_W-1:0]       mask_t;
  typedef mask_t [LANES-1:0]       row_t;
  typedef usage_t [REPORT_KEYS-1:0] key_list_t;

  typedef struct packed {
    logic [3:0] dev_id;
    logic [7:0] modifier_bits;
    logic [7:0] key_0;
    logic [7:0] key_1;
    logic [7:0] key_2;
    logic [7:0] key_3;
    logic [7:0] key_4;
    logic [7:0] key_5;
    logic [7:0] query_usage;
  } in_req_t;

  typedef struct packed {
    logic       accepted;
    logic       state_flip;
    logic [7:0] merged_modifiers;
    logic       query_pressed;
  } out_rsp_t;

  typedef enum logic [2:0] {
    ST_CLEAR,
    ST_IDLE,
    ST_WALK,
    ST_FLUSH,
    ST_QUERY,
    ST_RESULT
  } state_t;

  function automatic key_list_t report_keys(in_req_t r);
    usage_t    f [KEY_FIELDS];
    key_list_t k;
    f[0] = r.key_0;
    f[1] = r.key_1;
    f[2] = r.key_2;
    f[3] = r.key_3;
    f[4] = r.key_4;
    f[5] = r.key_5;
    k = '0;
    for (int i = 0; i < REPORT_KEYS; i++) begin
      if (i < KEY_FIELDS) begin
        k[i] = f[i];
      end
    end
    return k;
  endfunction

  function automatic logic report_error(key_list_t k);
    logic err;
    err = 1'b0;
    for (int i = 0; i < REPORT_KEYS; i++) begin
      if (k[i] >= ERR_FIRST && k[i] <= ERR_LAST) begin
        err = 1'b1;
      end
    end
    return err;
  endfunction

  function automatic mask_t device_bit(logic [3:0] dev);
    mask_t m;
    for (int i = 0; i < MASK_W; i++) begin
      m[i] = (dev == 4'(i));
    end
    return m;
  endfunction

endpackage

[src/multi_keyboard_report_merger.sv]
// Top level: keyboard report merger with a lane-parallel walk over the usage owner-mask memory.
// Accepted report: WALK reads every row of the mask memory, then FLUSH, QUERY and RESULT follow;
// the memory walk reads one row of four usage masks per cycle.
// Rejected report: no memory walk; only the query row is read (QUERY, then RESULT).
// One report in flight; the next is taken the cycle after the result is registered.
// Reset: synchronous; a clearing pass zeroes every row of the mask memory, input stalled meanwhile.
`timescale 1ns / 1ps
module multi_keyboard_report_merger (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              in_valid,
  output logic              in_stall,
  input  kmm_pkg::in_req_t  in_data,
  output logic              out_valid,
  input  logic              out_stall,
  output kmm_pkg::out_rsp_t out_data
);
  import kmm_pkg::*;

  state_t    state_r, state_nxt;
  logic [ROW_W-1:0] cnt_r, cnt_nxt;
  in_req_t   req_r;
  key_list_t keys_r;
  mask_t     dev_bit_r;
  logic      acc_r;
  logic      chg_r, chg_nxt;
  logic      rd_vld_r;
  logic [ROW_W-1:0] wr_row_r;
  row_t      rd_data_r;
  out_rsp_t  out_r;
  logic      out_valid_r;

  row_t      mem [ROWS];

  key_list_t in_keys;
  logic      acc_now;
  logic      take;
  logic      load_out;
  logic      rd_en;
  logic [ROW_W-1:0] rd_addr;
  logic      wr_en;
  logic [ROW_W-1:0] wr_addr;
  row_t      wr_data;
  row_t      lane_new;
  logic [LANES-1:0] lane_chg;
  logic [7:0] mod_merged;
  logic      mod_chg;
  logic [ROW_W-1:0]  q_row;
  logic [LANE_W-1:0] q_lane;
  logic      q_tracked;

  assign in_keys = report_keys(in_data);
  assign acc_now = (int'(in_data.dev_id) < MAX_DEVICES) && !report_error(in_keys);

  assign q_row     = ROW_W'(req_r.query_usage >> LANE_W);
  assign q_lane    = req_r.query_usage[LANE_W-1:0];
  assign q_tracked = (req_r.query_usage != '0) && (int'(req_r.query_usage) < USAGE_COUNT);

  kmm_mod_bank u_mod (
    .clk     (clk),
    .rst_n   (rst_n),
    .upd_en  (take && acc_now),
    .dev_bit (device_bit(in_data.dev_id)),
    .mods    (in_data.modifier_bits),
    .merged  (mod_merged),
    .changed (mod_chg)
  );

  for (genvar g = 0; g < LANES; g++) begin : g_lane
    logic [IDX_W-1:0] idx;
    assign idx = {wr_row_r, LANE_W'(g)};
    kmm_lane u_lane (
      .usage_id (usage_t'(idx)),
      .tracked  ((idx != '0) && (int'(idx) < USAGE_COUNT)),
      .keys     (keys_r),
      .dev_bit  (dev_bit_r),
      .old_mask (rd_data_r[g]),
      .new_mask (lane_new[g]),
      .changed  (lane_chg[g])
    );
  end

  // merge: sticky OR of lane flips
  assign chg_nxt = chg_r | (rd_vld_r && (|lane_chg));

  assign wr_en   = (state_r == ST_CLEAR) || rd_vld_r;
  assign wr_addr = (state_r == ST_CLEAR) ? cnt_r : wr_row_r;
  assign wr_data = (state_r == ST_CLEAR) ? '0 : lane_new;

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    if (rd_en) begin
      rd_data_r <= mem[rd_addr];
    end
  end

  always_comb begin
    state_nxt = state_r;
    cnt_nxt   = cnt_r;
    take      = 1'b0;
    load_out  = 1'b0;
    rd_en     = 1'b0;
    rd_addr   = cnt_r;
    in_stall  = (state_r != ST_IDLE);
    case (state_r)
      ST_CLEAR: begin
        cnt_nxt = cnt_r + 1'b1;
        if (cnt_r == ROW_W'(ROWS - 1)) begin
          cnt_nxt   = '0;
          state_nxt = ST_IDLE;
        end
      end
      ST_IDLE: begin
        if (in_valid) begin
          take      = 1'b1;
          cnt_nxt   = '0;
          state_nxt = acc_now ? ST_WALK : ST_QUERY;
        end
      end
      ST_WALK: begin
        rd_en   = 1'b1;
        cnt_nxt = cnt_r + 1'b1;
        if (cnt_r == ROW_W'(ROWS - 1)) begin
          cnt_nxt   = '0;
          state_nxt = ST_FLUSH;
        end
      end
      ST_FLUSH: begin
        state_nxt = ST_QUERY;
      end
      ST_QUERY: begin
        rd_en     = 1'b1;
        rd_addr   = q_row;
        state_nxt = ST_RESULT;
      end
      ST_RESULT: begin
        if (!out_valid_r || !out_stall) begin
          load_out  = 1'b1;
          state_nxt = ST_IDLE;
        end
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_CLEAR;
      cnt_r       <= '0;
      rd_vld_r    <= 1'b0;
      out_valid_r <= 1'b0;
      acc_r       <= 1'b0;
      chg_r       <= 1'b0;
    end else begin
      state_r  <= state_nxt;
      cnt_r    <= cnt_nxt;
      rd_vld_r <= (state_r == ST_WALK);
      if (take) begin
        acc_r <= acc_now;
        chg_r <= acc_now && mod_chg;
      end else begin
        chg_r <= chg_nxt;
      end
      if (load_out) begin
        out_valid_r <= 1'b1;
      end else if (!out_stall) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    wr_row_r <= cnt_r;
    if (take) begin
      req_r     <= in_data;
      keys_r    <= in_keys;
      dev_bit_r <= device_bit(in_data.dev_id);
    end
    if (load_out) begin
      out_r.accepted         <= acc_r;
      out_r.state_flip       <= chg_r;
      out_r.merged_modifiers <= mod_merged;
      out_r.query_pressed    <= q_tracked && (|rd_data_r[q_lane]);
    end
  end

  assign out_valid = out_valid_r;
  assign out_data  = out_r;

endmodule

[src/kmm_lane.sv]
// One usage lane: updates an owner mask against the report keys and flags an aggregate flip.
`timescale 1ns / 1ps
module kmm_lane (
  input  kmm_pkg::usage_t    usage_id,
  input  logic               tracked,
  input  kmm_pkg::key_list_t keys,
  input  kmm_pkg::mask_t     dev_bit,
  input  kmm_pkg::mask_t     old_mask,
  output kmm_pkg::mask_t     new_mask,
  output logic               changed
);
  import kmm_pkg::*;

  logic hit;

  always_comb begin
    hit = 1'b0;
    for (int i = 0; i < REPORT_KEYS; i++) begin
      if (keys[i] == usage_id) begin
        hit = 1'b1;
      end
    end
  end

  assign new_mask = tracked ? ((old_mask & ~dev_bit) | (hit ? dev_bit : '0)) : old_mask;
  assign changed  = (old_mask == '0) != (new_mask == '0);

endmodule

[src/kmm_mod_bank.sv]
// Modifier owner masks: one register per modifier, all updated together on upd_en.
`timescale 1ns / 1ps
module kmm_mod_bank (
  input  logic           clk,
  input  logic           rst_n,
  input  logic           upd_en,
  input  kmm_pkg::mask_t dev_bit,
  input  logic [7:0]     mods,
  output logic [7:0]     merged,
  output logic           changed
);
  import kmm_pkg::*;

  mask_t mask_r [MODIFIER_COUNT];
  mask_t mask_nxt [MODIFIER_COUNT];

  always_comb begin
    changed = 1'b0;
    merged  = '0;
    for (int n = 0; n < MODIFIER_COUNT; n++) begin
      mask_nxt[n] = (mask_r[n] & ~dev_bit) | (mods[n] ? dev_bit : '0);
      if ((mask_r[n] == '0) != (mask_nxt[n] == '0)) begin
        changed = 1'b1;
      end
      merged[n] = |mask_r[n];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int n = 0; n < MODIFIER_COUNT; n++) begin
        mask_r[n] <= '0;
      end
    end else if (upd_en) begin
      for (int n = 0; n < MODIFIER_COUNT; n++) begin
        mask_r[n] <= mask_nxt[n];
      end
    end
  end

endmodule

[src/kmm_checker.sv]
// Port-level checker for the report merger, bound to the top level.
`timescale 1ns / 1ps
module kmm_checker (
  input logic              clk,
  input logic              rst_n,
  input logic              in_valid,
  input logic              in_stall,
  input kmm_pkg::in_req_t  in_data,
  input logic              out_valid,
  input logic              out_stall,
  input kmm_pkg::out_rsp_t out_data
);
  import kmm_pkg::*;

  a_rej_no_change: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_data.accepted |-> !out_data.state_flip)
    else $error("rejected request reports a change");

  a_reset_stall: assert property (@(posedge clk)
    !rst_n |=> in_stall)
    else $error("input not stalled after reset");

  a_one_in_flight: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && !in_stall |=> in_stall)
    else $error("second request taken while one is in flight");

  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_stall |=> out_valid && $stable(out_data))
    else $error("stalled result dropped or changed");

  // result register frees up, then the rejected result shows
  a_bad_dev_rej: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && !in_stall && (int'(in_data.dev_id) >= MAX_DEVICES) |=>
      ##1 (!out_valid || !out_stall) [->1] ##1 (out_valid && !out_data.accepted))
    else $error("bad device index not rejected");

endmodule

bind multi_keyboard_report_merger kmm_checker u_kmm_checker (.*);
